>>> rtl/csfd_pkg.sv
// Package: shared types, character codes and decode helpers for the capability string field decoder.
`default_nettype none
package csfd_pkg;

  // Longest field length that is counted; the count saturates at the lower of this and 255
  localparam int unsigned MAX_FIELD_LEN = 255;
  localparam int unsigned LEN_CAP_INT   = (MAX_FIELD_LEN < 255) ? MAX_FIELD_LEN : 255;
  localparam logic [7:0]  LEN_CAP       = 8'(LEN_CAP_INT);

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_Z   = 8'h7A;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CARET_MASK = 8'hBF;
  localparam logic [7:0] CARET_NUL  = 8'h80;
  localparam logic [7:0] CASE_DIFF  = 8'h20;

  // Parser states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LIT,
    ST_SYM,
    ST_CARET,
    ST_ESCAPE,
    ST_OCT1,
    ST_OCT2
  } pstate_t;

  // Parser context carried from byte to byte
  typedef struct packed {
    pstate_t    state;
    logic [7:0] acc;
    logic [7:0] len;
    logic       kind;
  } ctx_t;

  // One result beat
  typedef struct packed {
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       field_done;
    logic       field_kind;
    logic [7:0] field_length;
    logic       terminated;
    logic       syntax_error;
  } res_t;

  // Named backslash escapes; anything else stands for itself
  function automatic logic [7:0] escape_value(input logic [7:0] b);
    logic [7:0] v;
    case (b)
      8'h45, 8'h65: v = CH_ESC;  // E e
      8'h6E, 8'h6C: v = 8'h0A;   // n l
      8'h72:        v = 8'h0D;   // r
      8'h74:        v = 8'h09;   // t
      8'h62:        v = 8'h08;   // b
      8'h66:        v = 8'h0C;   // f
      8'h73:        v = 8'h20;   // s
      default:      v = b;
    endcase
    return v;
  endfunction

  // Caret control code: uppercase, clear bit 6, zero maps to 0x80, '?' is DEL
  function automatic logic [7:0] caret_value(input logic [7:0] b);
    logic [7:0] u;
    u = b;
    if (b >= CH_LC_A && b <= CH_LC_Z) begin
      u = b - CASE_DIFF;
    end
    u = u & CARET_MASK;
    if (b == CH_QMARK) begin
      return CH_DEL;
    end
    return (u == 8'h00) ? CARET_NUL : u;
  endfunction

  // Saturating length step
  function automatic logic [7:0] len_inc(input logic [7:0] len);
    return (len < LEN_CAP) ? len + 8'd1 : len;
  endfunction

endpackage
`default_nettype wire

>>> rtl/csfd_decode.sv
// Per-byte decode: next parser context and the result beat for one raw byte.
`default_nettype none
module csfd_decode
  import csfd_pkg::*;
(
  input  wire logic [7:0] byte_i,
  input  wire ctx_t       ctx_i,
  output ctx_t            ctx_o,
  output res_t            res_o
);

  logic       is_nul;
  logic       is_digit;
  logic [7:0] digit;
  logic [7:0] oct_sum;
  logic [7:0] len_emit;
  logic [7:0] len_first;

  // Shared byte classification and arithmetic
  always_comb begin
    is_nul    = (byte_i == CH_NUL);
    is_digit  = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
    digit     = byte_i - CH_ZERO;
    oct_sum   = ctx_i.acc + digit;
    len_emit  = len_inc(ctx_i.len);
    len_first = len_inc(8'h00);
  end

  // Next-state logic
  always_comb begin
    ctx_o = ctx_i;
    case (ctx_i.state)
      ST_LIT: begin
        if (is_nul || byte_i == CH_QUOTE) begin
          ctx_o.state = ST_IDLE;
          ctx_o.len   = 8'h00;
        end else if (byte_i == CH_BSLASH) begin
          ctx_o.state = ST_ESCAPE;
        end else if (byte_i == CH_CARET) begin
          ctx_o.state = ST_CARET;
        end else begin
          ctx_o.len = len_emit;
        end
      end
      ST_SYM: begin
        if (is_nul || byte_i == CH_PIPE || byte_i == CH_QUOTE ||
            byte_i == CH_BSLASH || byte_i == CH_CARET) begin
          ctx_o.state = ST_IDLE;
          ctx_o.len   = 8'h00;
        end else begin
          ctx_o.len = len_emit;
        end
      end
      ST_CARET: begin
        if (is_nul || byte_i == CH_QUOTE) begin
          ctx_o.state = ST_IDLE;
          ctx_o.len   = 8'h00;
        end else begin
          ctx_o.state = ST_LIT;
          ctx_o.len   = len_emit;
        end
      end
      ST_ESCAPE: begin
        if (is_nul) begin
          ctx_o.state = ST_IDLE;
          ctx_o.len   = 8'h00;
        end else if (is_digit) begin
          ctx_o.acc   = {digit[1:0], 6'h00};
          ctx_o.state = ST_OCT1;
        end else begin
          ctx_o.state = ST_LIT;
          ctx_o.len   = len_emit;
        end
      end
      ST_OCT1: begin
        if (is_nul) begin
          ctx_o.state = ST_IDLE;
          ctx_o.len   = 8'h00;
        end else begin
          ctx_o.acc   = ctx_i.acc + {digit[4:0], 3'h0};
          ctx_o.state = ST_OCT2;
        end
      end
      ST_OCT2: begin
        if (is_nul) begin
          ctx_o.state = ST_IDLE;
          ctx_o.len   = 8'h00;
        end else begin
          ctx_o.acc   = oct_sum;
          ctx_o.state = ST_LIT;
          ctx_o.len   = len_emit;
        end
      end
      default: begin
        // Between fields
        ctx_o.state = ST_IDLE;
        ctx_o.len   = 8'h00;
        if (is_nul || byte_i == CH_PIPE || byte_i == CH_BSLASH || byte_i == CH_CARET) begin
          ctx_o.state = ST_IDLE;
        end else if (byte_i == CH_QUOTE) begin
          ctx_o.kind  = 1'b0;
          ctx_o.state = ST_LIT;
        end else begin
          ctx_o.kind  = 1'b1;
          ctx_o.len   = len_first;
          ctx_o.state = ST_SYM;
        end
      end
    endcase
  end

  // Output logic
  always_comb begin
    res_o = '0;
    case (ctx_i.state)
      ST_LIT: begin
        if (is_nul) begin
          res_o.syntax_error = 1'b1;
        end else if (byte_i == CH_QUOTE) begin
          res_o.field_done   = 1'b1;
          res_o.field_kind   = ctx_i.kind;
          res_o.field_length = ctx_i.len;
        end else if (byte_i == CH_BSLASH || byte_i == CH_CARET) begin
          res_o.field_length = ctx_i.len;
        end else begin
          res_o.byte_valid   = 1'b1;
          res_o.out_byte     = byte_i;
          res_o.field_length = len_emit;
        end
      end
      ST_SYM: begin
        if (is_nul || byte_i == CH_PIPE) begin
          res_o.field_done   = 1'b1;
          res_o.field_kind   = ctx_i.kind;
          res_o.field_length = ctx_i.len;
          res_o.terminated   = is_nul;
        end else if (byte_i == CH_QUOTE || byte_i == CH_BSLASH || byte_i == CH_CARET) begin
          res_o.syntax_error = 1'b1;
        end else begin
          res_o.byte_valid   = 1'b1;
          res_o.out_byte     = byte_i;
          res_o.field_length = len_emit;
        end
      end
      ST_CARET: begin
        if (is_nul || byte_i == CH_QUOTE) begin
          res_o.syntax_error = 1'b1;
        end else begin
          res_o.byte_valid   = 1'b1;
          res_o.out_byte     = caret_value(byte_i);
          res_o.field_length = len_emit;
        end
      end
      ST_ESCAPE: begin
        if (is_nul) begin
          res_o.syntax_error = 1'b1;
        end else if (is_digit) begin
          res_o.field_length = ctx_i.len;
        end else begin
          res_o.byte_valid   = 1'b1;
          res_o.out_byte     = escape_value(byte_i);
          res_o.field_length = len_emit;
        end
      end
      ST_OCT1: begin
        if (is_nul) begin
          res_o.syntax_error = 1'b1;
        end else begin
          res_o.field_length = ctx_i.len;
        end
      end
      ST_OCT2: begin
        if (is_nul) begin
          res_o.syntax_error = 1'b1;
        end else begin
          res_o.byte_valid   = 1'b1;
          res_o.out_byte     = oct_sum;
          res_o.field_length = len_emit;
        end
      end
      default: begin
        if (is_nul) begin
          res_o.terminated = 1'b1;
        end else if (byte_i == CH_BSLASH || byte_i == CH_CARET) begin
          res_o.syntax_error = 1'b1;
        end else if (byte_i != CH_QUOTE && byte_i != CH_PIPE) begin
          res_o.byte_valid   = 1'b1;
          res_o.out_byte     = byte_i;
          res_o.field_length = len_first;
        end
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/capability_string_field_decoder_core.sv
// Top level: input register, per-byte decode and result register of the field decoder.
// A byte accepted into the input register is decoded combinationally and loads the result register,
// where its result beat waits until out_ready takes it.
// Throughput: one byte per cycle while out_ready stays high; the parser context update sets the rate.
// While a result waits on out_ready the input register takes at most one more byte,
// then in_ready stays low until the result beat leaves.
// Reset (rst_n low, synchronous) empties both registers and returns the parser to
// the between-fields state with zero length, octal accumulator and field kind.
`default_nettype none
module capability_string_field_decoder_core
  import csfd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_byte_valid,
  output logic [7:0]      out_byte,
  output logic            out_field_done,
  output logic            out_field_kind,
  output logic [7:0]      out_field_length,
  output logic            out_terminated,
  output logic            out_syntax_error
);

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  ctx_t       ctx_r;
  ctx_t       ctx_nxt;
  res_t       res_r;
  res_t       res_nxt;
  logic       out_valid_r;
  logic       advance;

  // Stage handshake
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !in_valid_r || advance;

  csfd_decode u_decode (
    .byte_i (in_byte_r),
    .ctx_i  (ctx_r),
    .ctx_o  (ctx_nxt),
    .res_o  (res_nxt)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_byte;
    end
  end

  // Parser context and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r       <= '{state: ST_IDLE, acc: 8'h00, len: 8'h00, kind: 1'b0};
      out_valid_r <= 1'b0;
    end else if (in_valid_r && advance) begin
      ctx_r       <= ctx_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r && advance) begin
      res_r <= res_nxt;
    end
  end

  // Result beat
  assign out_valid        = out_valid_r;
  assign out_byte_valid   = res_r.byte_valid;
  assign out_byte         = res_r.out_byte;
  assign out_field_done   = res_r.field_done;
  assign out_field_kind   = res_r.field_kind;
  assign out_field_length = res_r.field_length;
  assign out_terminated   = res_r.terminated;
  assign out_syntax_error = res_r.syntax_error;

  // Checks
  a_done_xor_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.field_done && res_r.syntax_error))
    else $error("field end and syntax error in one beat");

  a_err_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.syntax_error |-> res_r.field_length == 8'h00 && !res_r.byte_valid)
    else $error("dropped field reports length or data");

  a_byte_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.byte_valid |-> res_r.field_length != 8'h00)
    else $error("decoded byte with zero field length");

  a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
    ctx_r.len <= LEN_CAP)
    else $error("field length above cap");

  a_hold_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(in_byte_r) && $stable(ctx_r))
    else $error("input register lost a byte during stall");

endmodule
`default_nettype wire

>>> test/testbench.sv
// Testbench for the capability string field decoder: scoreboard, byte driver, result checker.
module testbench;
  import csfd_pkg::*;

  localparam int NUM_BYTES   = 1950;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 150;

  // Opening bytes: pipe between fields, symbol closed by a zero, bare zero,
  // empty literal, literal with named escape, octal code, caret codes, pipe and
  // 0xFF inside it, backslash at field start, quote after caret, zero in literal.
  localparam logic [7:0] OPENING [27] = '{
    CH_PIPE,
    "a", "b", CH_NUL,
    CH_NUL,
    CH_QUOTE, CH_QUOTE,
    CH_QUOTE, CH_BSLASH, "n", CH_BSLASH, "1", "0", "1", CH_CARET, CH_QMARK,
    CH_CARET, "a", CH_PIPE, 8'hFF, CH_QUOTE,
    CH_BSLASH,
    CH_QUOTE, CH_CARET, CH_QUOTE,
    CH_QUOTE, CH_NUL
  };

  localparam logic [7:0] ESC_LETTERS [10] = '{"E", "e", "n", "l", "r", "t", "b", "f", "s", "x"};

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic [7:0] in_byte   = 8'h00;
  logic       out_ready = 1'b0;
  wire        in_ready;
  wire        out_valid;
  wire        out_byte_valid;
  wire  [7:0] out_byte;
  wire        out_field_done;
  wire        out_field_kind;
  wire  [7:0] out_field_length;
  wire        out_terminated;
  wire        out_syntax_error;

  capability_string_field_decoder_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte_valid   (out_byte_valid),
    .out_byte         (out_byte),
    .out_field_done   (out_field_done),
    .out_field_kind   (out_field_kind),
    .out_field_length (out_field_length),
    .out_terminated   (out_terminated),
    .out_syntax_error (out_syntax_error)
  );

  // Parser mirror plus the queue of result beats it predicts
  class field_scoreboard;
    pstate_t    st;
    logic [7:0] acc;
    logic [7:0] len;
    logic       kind;
    res_t       want_q[$];
    int         errors;
    int         fields;
    int         saturated;
    int         terms;
    int         drops;

    function new();
      st        = ST_IDLE;
      acc       = '0;
      len       = '0;
      kind      = 1'b0;
      errors    = 0;
      fields    = 0;
      saturated = 0;
      terms     = 0;
      drops     = 0;
    endfunction

    function int pending();
      return want_q.size();
    endfunction

    // Decoded byte goes out; length counts up to the cap
    function void put(inout res_t r, input logic [7:0] v);
      r.byte_valid = 1'b1;
      r.out_byte   = v;
      if (len < LEN_CAP) len = len + 8'd1;
    endfunction

    // Malformed field: dropped, back between fields
    function void drop(inout res_t r);
      r.syntax_error = 1'b1;
      len            = '0;
      st             = ST_IDLE;
    endfunction

    function void close_field(inout res_t r);
      r.field_done   = 1'b1;
      r.field_kind   = kind;
      r.field_length = len;
      len            = '0;
      st             = ST_IDLE;
    endfunction

    // Accepted input beat: advance the mirror and queue the expected result
    function void note_byte(logic [7:0] b);
      res_t       r;
      logic [7:0] u;
      r = '0;
      case (st)
        ST_LIT: begin
          if (b == CH_NUL) drop(r);
          else if (b == CH_QUOTE) close_field(r);
          else if (b == CH_BSLASH) st = ST_ESCAPE;
          else if (b == CH_CARET) st = ST_CARET;
          else put(r, b);
        end
        ST_SYM: begin
          if (b == CH_NUL) begin
            close_field(r);
            r.terminated = 1'b1;
          end else if (b == CH_PIPE) close_field(r);
          else if (b == CH_QUOTE || b == CH_BSLASH || b == CH_CARET) drop(r);
          else put(r, b);
        end
        ST_CARET: begin
          if (b == CH_NUL || b == CH_QUOTE) drop(r);
          else begin
            if (b == CH_QMARK) begin
              u = CH_DEL;
            end else begin
              u = (b >= CH_LC_A && b <= CH_LC_Z) ? b - CASE_DIFF : b;
              u = u & CARET_MASK;
              if (u == 8'h00) u = CARET_NUL;
            end
            put(r, u);
            st = ST_LIT;
          end
        end
        ST_ESCAPE: begin
          if (b == CH_NUL) drop(r);
          else if (b >= CH_ZERO && b <= CH_NINE) begin
            acc = (b - CH_ZERO) << 6;
            st  = ST_OCT1;
          end else begin
            case (b)
              "E", "e": u = CH_ESC;
              "n", "l": u = 8'h0A;
              "r":      u = 8'h0D;
              "t":      u = 8'h09;
              "b":      u = 8'h08;
              "f":      u = 8'h0C;
              "s":      u = 8'h20;
              default:  u = b;
            endcase
            put(r, u);
            st = ST_LIT;
          end
        end
        ST_OCT1: begin
          if (b == CH_NUL) drop(r);
          else begin
            acc = acc + ((b - CH_ZERO) << 3);
            st  = ST_OCT2;
          end
        end
        ST_OCT2: begin
          if (b == CH_NUL) drop(r);
          else begin
            acc = acc + (b - CH_ZERO);
            put(r, acc);
            st = ST_LIT;
          end
        end
        default: begin
          st  = ST_IDLE;
          len = '0;
          if (b == CH_NUL) r.terminated = 1'b1;
          else if (b == CH_QUOTE) begin
            kind = 1'b0;
            st   = ST_LIT;
          end else if (b == CH_PIPE) begin
            // separator between fields, nothing to do
          end else if (b == CH_BSLASH || b == CH_CARET) drop(r);
          else begin
            kind = 1'b1;
            put(r, b);
            st = ST_SYM;
          end
        end
      endcase
      if (!r.field_done) r.field_length = len;
      want_q.push_back(r);
    endfunction

    function void cmp(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    // Output beat: compare against the oldest prediction
    function void check_result(res_t got);
      res_t want;
      if (want_q.size() == 0) begin
        $error("result beat with no byte pending: %h", got);
        errors++;
        return;
      end
      want = want_q.pop_front();
      cmp("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
      cmp("out_byte", want.out_byte, got.out_byte);
      cmp("field_done", 8'(want.field_done), 8'(got.field_done));
      cmp("field_kind", 8'(want.field_kind), 8'(got.field_kind));
      cmp("field_length", want.field_length, got.field_length);
      cmp("terminated", 8'(want.terminated), 8'(got.terminated));
      cmp("syntax_error", 8'(want.syntax_error), 8'(got.syntax_error));
      if (want.field_done) fields++;
      if (want.field_done && want.field_length == LEN_CAP) saturated++;
      if (want.terminated) terms++;
      if (want.syntax_error) drops++;
    endfunction
  endclass

  field_scoreboard sb = new();
  int sent      = 0;
  int cycles    = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  // Window with no idling on either side
  wire calm = (sent >= 1200 && sent < 1500);

  always #5 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: check each beat, random stalls, one long hold-off
  always @(posedge clk) begin : rx_side
    res_t got;
    got = {out_byte_valid, out_byte, out_field_done, out_field_kind, out_field_length,
           out_terminated, out_syntax_error};
    if (rst_n && out_valid && out_ready) sb.check_result(got);
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && sent >= 600) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 8);
    end
  end

  // One input beat, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_byte(b);
    sent++;
  endtask

  // Stop offering until every predicted beat has come back
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Ordinary character; a pipe is ordinary only inside a literal
  function automatic logic [7:0] plain_char(input bit allow_pipe);
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (c == CH_QUOTE || c == CH_BSLASH || c == CH_CARET || (!allow_pipe && c == CH_PIPE));
    return c;
  endfunction

  task automatic send_symbol(input int n);
    repeat (n) send_byte(plain_char(1'b0));
    send_byte(($urandom_range(0, 9) == 0) ? CH_NUL : CH_PIPE);
  endtask

  // Quoted literal of n decoded bytes: plain, escapes, octal codes, caret codes
  task automatic send_literal(input int n);
    logic [7:0] c;
    send_byte(CH_QUOTE);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: send_byte(plain_char(1'b1));
        5, 6: begin
          send_byte(CH_BSLASH);
          if ($urandom_range(0, 1)) begin
            send_byte(ESC_LETTERS[$urandom_range(0, 9)]);
          end else begin
            do c = 8'($urandom_range(1, 255));
            while (c >= CH_ZERO && c <= CH_NINE);
            send_byte(c);
          end
        end
        7, 8: begin
          send_byte(CH_BSLASH);
          send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
          repeat (2) begin
            if ($urandom_range(0, 3) != 0) send_byte(CH_ZERO + 8'($urandom_range(0, 7)));
            else send_byte(8'($urandom_range(1, 255)));
          end
        end
        default: begin
          send_byte(CH_CARET);
          if ($urandom_range(0, 3) == 0) begin
            send_byte(CH_QMARK);
          end else begin
            do c = 8'($urandom_range(1, 255));
            while (c == CH_QUOTE);
            send_byte(c);
          end
        end
      endcase
    end
    send_byte(CH_QUOTE);
  endtask

  // Main sequence
  initial begin
    int  field_no;
    int  pick;
    bit  paused;
    field_no = 0;
    paused   = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (OPENING[i]) send_byte(OPENING[i]);
    wait_drain();

    // Mostly well-formed fields, some raw noise; first two fields overflow the length
    while (sent < NUM_BYTES) begin
      if (!paused && sent >= 1000) begin
        wait_drain();
        paused = 1'b1;
      end
      if (field_no == 0) begin
        send_symbol(270);
      end else if (field_no == 1) begin
        send_literal(260);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 10) repeat ($urandom_range(1, 3)) send_byte(8'($urandom()));
        else if (pick < 50) send_symbol($urandom_range(1, 8));
        else send_literal($urandom_range(0, 8));
        if ($urandom_range(0, 3) == 0) send_byte(CH_PIPE);
        if ($urandom_range(0, 19) == 0) send_byte(CH_NUL);
      end
      field_no++;
    end

    wait_drain();
    repeat (8) @(posedge clk);
    $display("Fed %0d bytes; %0d fields closed, %0d with saturated length.",
             sent, sb.fields, sb.saturated);
    $display("%0d string ends and %0d dropped fields checked.", sb.terms, sb.drops);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
